[sv/gamepad_frame_receiver_core_defines.svh]
// ---------------------------------------------------------------------------
// Gamepad frame receiver: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef GAMEPAD_FRAME_RECEIVER_CORE_DEFINES_SVH
`define GAMEPAD_FRAME_RECEIVER_CORE_DEFINES_SVH

// Property that holds at every clock edge outside reset
`define GFR_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define GFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/gfr_pkg.sv]
// ---------------------------------------------------------------------------
// Gamepad frame receiver: package
// Frame constants, report layout and the word moved to the output queue.
// ---------------------------------------------------------------------------
package gfr_pkg;

    // Frame framing
    localparam logic [7:0] START_BYTE = 8'h80;
    localparam logic [3:0] FRAME_LAST = 4'd11;

    // Register map (word index) and reset value
    localparam logic [0:0] REG_DEADZONE   = 1'b0;
    localparam logic [6:0] DEADZONE_RESET = 7'd8;

    // Payload bytes 1..10 of a frame
    typedef logic [10:1][7:0] payload_t;

    // Unpacked report, high field first in the 64-bit layout
    typedef struct packed {
        logic [7:0]  right_y;
        logic [7:0]  right_x;
        logic [7:0]  left_y;
        logic [7:0]  left_x;
        logic [7:0]  right_trigger;
        logic [7:0]  left_trigger;
        logic [15:0] buttons;
    } report_t;

    // One result word
    typedef struct packed {
        logic    checksum_ok;
        report_t report;
    } result_t;

    // Push request into the output queue
    typedef struct packed {
        logic    valid;
        result_t result;
    } push_t;

endpackage

[sv/gfr_unpack.sv]
// ---------------------------------------------------------------------------
// Gamepad frame receiver: report unpacker
// Pulls buttons, triggers and stick axes out of the 7-bit payload bytes and
// applies the stick dead zone.
// ---------------------------------------------------------------------------
module gfr_unpack (
    input  gfr_pkg::payload_t payload,
    input  logic [6:0]        deadzone,
    output gfr_pkg::report_t  report
);

    // Center at 128, zero inside the dead zone, shrink by it outside
    function automatic logic [7:0] shape_axis(input logic [7:0] raw, input logic [6:0] db);
        logic signed [8:0] v;
        logic signed [8:0] mag;
        logic signed [8:0] dbs;
        logic signed [8:0] res;
        v   = $signed({1'b0, raw}) - 9'sd128;
        mag = v[8] ? -v : v;
        dbs = $signed({2'b00, db});
        if (mag <= dbs)
            res = 9'sd0;
        else if (v[8])
            res = v + dbs;
        else
            res = v - dbs;
        return res[7:0];
    endfunction

    logic [7:0] lx_raw;
    logic [7:0] ly_raw;
    logic [7:0] rx_raw;
    logic [7:0] ry_raw;

    // Raw axis bit gathering
    assign lx_raw = {payload[5][2:0], payload[6][6:2]};
    assign ly_raw = {payload[6][1:0], payload[7][6:1]};
    assign rx_raw = {payload[7][0],   payload[8][6:0]};
    assign ry_raw = {payload[9][6:0], payload[10][6]};

    // Report fields
    always_comb
    begin
        report.buttons       = {payload[3][6:5], payload[2][6:0], payload[1][6:0]};
        report.left_trigger  = {payload[3][4:0], payload[4][6:4]};
        report.right_trigger = {payload[4][3:0], payload[5][6:3]};
        report.left_x        = shape_axis(lx_raw, deadzone);
        report.left_y        = shape_axis(ly_raw, deadzone);
        report.right_x       = shape_axis(rx_raw, deadzone);
        report.right_y       = shape_axis(ry_raw, deadzone);
    end

endmodule

[sv/gfr_out_queue.sv]
// ---------------------------------------------------------------------------
// Gamepad frame receiver: output queue
// Two-word result queue that decouples the frame logic from the consumer.
// ---------------------------------------------------------------------------
module gfr_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  gfr_pkg::push_t    push,
    input  logic              pop,
    output gfr_pkg::result_t  head,
    output logic              head_valid,
    output logic              has_space
);

    gfr_pkg::result_t slot_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_pop;

    assign head_valid = (count_reg != 2'd0);
    assign has_space  = (count_reg != 2'd2);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push.valid ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push.valid} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (push.valid)
            slot_reg[wr_ptr_reg] <= push.result;
    end

endmodule

[sv/gamepad_frame_receiver_core.sv]
// ---------------------------------------------------------------------------
// Gamepad frame receiver core
// Frames 12-byte controller reports from a byte stream, checks the sum byte
// and delivers the last good report on every completed frame.
// ---------------------------------------------------------------------------
// The block takes one byte per clock cycle while in_ready is high. Each
// accepted byte is registered and processed from that register; a frame's
// result word passes the input register and the output queue on its way out.
// A two-word output queue holds results while the consumer stalls; input
// stalls only when a frame completes while both queue slots are occupied.
// The dead zone register lives at byte address 0 of the APB port.
`include "gamepad_frame_receiver_core_defines.svh"

module gamepad_frame_receiver_core (
    input  logic              clk,
    input  logic              rst_n,
    // APB configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // Byte input
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        rx_byte,
    // Report output
    output logic              out_valid,
    input  logic              out_ready,
    output logic              checksum_ok,
    output logic [15:0]       buttons,
    output logic [7:0]        left_trigger,
    output logic [7:0]        right_trigger,
    output logic signed [7:0] left_x,
    output logic signed [7:0] left_y,
    output logic signed [7:0] right_x,
    output logic signed [7:0] right_y
);

    logic [6:0]        deadzone_reg;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [7:0]        s1_byte_reg;
    logic [3:0]        pos_reg;
    logic [3:0]        pos_next;
    logic [7:0]        sum_reg;
    logic [7:0]        sum_next;
    gfr_pkg::payload_t frame_bytes_reg;
    gfr_pkg::report_t  report_reg;
    gfr_pkg::report_t  report_next;
    gfr_pkg::report_t  unpacked;
    gfr_pkg::push_t    push;
    gfr_pkg::result_t  head;
    logic              has_space;
    logic              cfg_write;
    logic              s1_start;
    logic              s1_done;
    logic              s1_ok;
    logic              s1_advance;
    logic              s1_fire;
    logic              store_byte;

    // APB register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == gfr_pkg::REG_DEADZONE) ? {25'd0, deadzone_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            deadzone_reg <= gfr_pkg::DEADZONE_RESET;
        else if (cfg_write && (paddr[2] == gfr_pkg::REG_DEADZONE))
            deadzone_reg <= pwdata[6:0];
    end

    // Input register handshake
    assign s1_start   = (s1_byte_reg == gfr_pkg::START_BYTE);
    assign s1_done    = !s1_start && (pos_reg == gfr_pkg::FRAME_LAST);
    assign s1_ok      = (sum_reg == s1_byte_reg);
    assign s1_advance = !s1_done || has_space;
    assign s1_fire    = s1_valid_reg && s1_advance;
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_byte_reg <= rx_byte;
    end

    // Frame tracking: position and running sum
    always_comb
    begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        store_byte = 1'b0;
        if (s1_fire)
        begin
            priority if (s1_start)
            begin
                pos_next = 4'd1;
                sum_next = gfr_pkg::START_BYTE;
            end
            else if ((pos_reg == 4'd0) || (pos_reg > gfr_pkg::FRAME_LAST))
                pos_next = 4'd0;
            else if (pos_reg < gfr_pkg::FRAME_LAST)
            begin
                store_byte = 1'b1;
                sum_next   = sum_reg + s1_byte_reg;
                pos_next   = pos_reg + 4'd1;
            end
            else
                pos_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 4'd0;
            sum_reg <= 8'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    // Payload byte storage
    always_ff @(posedge clk)
    begin
        for (int i = 1; i <= 10; i++)
        begin
            if (store_byte && (pos_reg == 4'(i)))
                frame_bytes_reg[i] <= s1_byte_reg;
        end
    end

    gfr_unpack u_unpack (
        .payload  (frame_bytes_reg),
        .deadzone (deadzone_reg),
        .report   (unpacked)
    );

    // Result word and last good report
    always_comb
    begin
        push.valid              = s1_fire && s1_done;
        push.result.checksum_ok = s1_ok;
        push.result.report      = s1_ok ? unpacked : report_reg;
        report_next             = (push.valid && s1_ok) ? unpacked : report_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            report_reg <= '0;
        else
            report_reg <= report_next;
    end

    gfr_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (out_ready),
        .head       (head),
        .head_valid (out_valid),
        .has_space  (has_space)
    );

    // Output fields
    assign checksum_ok   = head.checksum_ok;
    assign buttons       = head.report.buttons;
    assign left_trigger  = head.report.left_trigger;
    assign right_trigger = head.report.right_trigger;
    assign left_x        = $signed(head.report.left_x);
    assign left_y        = $signed(head.report.left_y);
    assign right_x       = $signed(head.report.right_x);
    assign right_y       = $signed(head.report.right_y);

    // Checks
    `GFR_ASSERT_ALWAYS(a_pos_range, pos_reg <= gfr_pkg::FRAME_LAST, "frame position out of range")
    `GFR_ASSERT_NEXT(a_stall_holds, s1_valid_reg && s1_done && !has_space, s1_valid_reg && $stable(s1_byte_reg), "completed frame lost while queue full")
    `GFR_ASSERT_NEXT(a_good_updates, push.valid && s1_ok, report_reg == $past(unpacked), "good frame did not update report")
    `GFR_ASSERT_NEXT(a_bad_keeps, push.valid && !s1_ok, $stable(report_reg), "bad frame changed report")

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Gamepad frame receiver testbench
// Drives a byte stream of well-formed, corrupted, truncated and stray frames
// and checks every report word against an in-bench model of the framer,
// the checksum and the dead zone shaping. The dead zone register is written
// over the APB port between phases, and both handshakes idle at random.
// ---------------------------------------------------------------------------
module testbench;

    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         LATENCY_PAD    = 8;
    localparam logic [2:0] DEADZONE_ADDR  = {gfr_pkg::REG_DEADZONE, 2'b00};
    localparam logic [2:0] SPARE_ADDR     = 3'd4;

    typedef logic [0:11][7:0] frame_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_ready;
    logic [7:0]        rx_byte;
    logic              out_valid;
    logic              out_ready;
    logic              checksum_ok;
    logic [15:0]       buttons;
    logic [7:0]        left_trigger;
    logic [7:0]        right_trigger;
    logic signed [7:0] left_x;
    logic signed [7:0] left_y;
    logic signed [7:0] right_x;
    logic signed [7:0] right_y;

    // Model state
    logic [6:0]        model_deadzone;
    logic [3:0]        model_position;
    logic [7:0]        model_sum;
    gfr_pkg::payload_t model_payload;
    gfr_pkg::report_t  model_report;
    gfr_pkg::result_t  pending_reports[$];

    // Run bookkeeping
    int   errors;
    int   bytes_sent;
    int   idle_cycles;
    logic quiet;

    gfr_pkg::result_t observed;
    gfr_pkg::result_t wanted;

    gamepad_frame_receiver_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .checksum_ok  (checksum_ok),
        .buttons      (buttons),
        .left_trigger (left_trigger),
        .right_trigger(right_trigger),
        .left_x       (left_x),
        .left_y       (left_y),
        .right_x      (right_x),
        .right_y      (right_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // Helpers
    // ---------------------------------------------------------------------
    task automatic log_error(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
            log_error($sformatf("%s expected %h got %h", name, want, got));
    endtask

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 97)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Center at 128, zero inside the dead zone, shrink outside it
    function automatic logic [7:0] shape_stick(input logic [7:0] raw,
                                               input logic [6:0] db);
        int v;
        int mag;
        v   = int'(raw) - 128;
        mag = (v < 0) ? -v : v;
        if (mag <= int'(db))
            v = 0;
        else if (v < 0)
            v = v + int'(db);
        else
            v = v - int'(db);
        return v[7:0];
    endfunction

    // Unpack the 7-bit payload bytes into a report
    function automatic gfr_pkg::report_t unpack_frame(input gfr_pkg::payload_t p,
                                                      input logic [6:0] db);
        gfr_pkg::report_t r;
        r.buttons       = {p[3][6:5], p[2][6:0], p[1][6:0]};
        r.left_trigger  = {p[3][4:0], p[4][6:4]};
        r.right_trigger = {p[4][3:0], p[5][6:3]};
        r.left_x        = shape_stick({p[5][2:0], p[6][6:2]}, db);
        r.left_y        = shape_stick({p[6][1:0], p[7][6:1]}, db);
        r.right_x       = shape_stick({p[7][0], p[8][6:0]}, db);
        r.right_y       = shape_stick({p[9][6:0], p[10][6]}, db);
        return r;
    endfunction

    // Framer model: one call per accepted byte
    task automatic model_take_byte(input logic [7:0] b);
        logic good;
        if (b == gfr_pkg::START_BYTE)
        begin
            model_position = 4'd1;
            model_sum      = gfr_pkg::START_BYTE;
        end
        else if (model_position == 4'd0 || model_position > gfr_pkg::FRAME_LAST)
            model_position = 4'd0;
        else if (model_position < gfr_pkg::FRAME_LAST)
        begin
            model_payload[model_position] = b;
            model_sum      = model_sum + b;
            model_position = model_position + 4'd1;
        end
        else
        begin
            good = (model_sum == b);
            if (good)
                model_report = unpack_frame(model_payload, model_deadzone);
            model_position = 4'd0;
            pending_reports.push_back({good, model_report});
        end
    endtask

    // Encode a report into a frame; dirty sets don't-care bits at random
    function automatic frame_t build_frame(input logic [15:0] btn, input logic [7:0] lt,
                                           input logic [7:0] rt, input logic [7:0] lx,
                                           input logic [7:0] ly, input logic [7:0] rx,
                                           input logic [7:0] ry, input logic dirty);
        frame_t f;
        logic [7:0] s;
        f[0]  = gfr_pkg::START_BYTE;
        f[1]  = {1'b0, btn[6:0]};
        f[2]  = {1'b0, btn[13:7]};
        f[3]  = {1'b0, btn[15:14], lt[7:3]};
        f[4]  = {1'b0, lt[2:0], rt[7:4]};
        f[5]  = {1'b0, rt[3:0], lx[7:5]};
        f[6]  = {1'b0, lx[4:0], ly[7:6]};
        f[7]  = {1'b0, ly[5:0], rx[7]};
        f[8]  = {1'b0, rx[6:0]};
        f[9]  = {1'b0, ry[7:1]};
        f[10] = {1'b0, ry[0], 6'b0};
        if (dirty)
        begin
            f[10][5:0] = 6'($urandom);
            // bit 7 is ignored, but a bare 0x80 would restart the frame
            for (int i = 1; i <= 10; i++)
                if ($urandom_range(0, 1) == 1 && f[i][6:0] != 7'd0)
                    f[i][7] = 1'b1;
        end
        s = 8'd0;
        for (int i = 0; i <= 10; i++)
            s = s + f[i];
        f[11] = s;
        return f;
    endfunction

    // Stick raw value, biased toward the dead zone edges
    function automatic logic [7:0] pick_axis();
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r < 4)
        begin
            v = int'(model_deadzone) + $urandom_range(0, 2) - 1;
            v = ($urandom_range(0, 1) == 1) ? 128 + v : 128 - v;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
        end
        else if (r == 4)
            v = 0;
        else if (r == 5)
            v = 255;
        else if (r == 6)
            v = 128;
        else
            v = $urandom_range(0, 255);
        return v[7:0];
    endfunction

    // ---------------------------------------------------------------------
    // Byte sender and APB access
    // ---------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        model_take_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input frame_t f, input int count);
        for (int i = 0; i < count; i++)
            send_byte(f[i]);
    endtask

    // Stop sending and wait until every expected word has come out
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (LATENCY_PAD) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write dead zone while idle, then read it back
    task automatic set_deadzone(input logic [31:0] word);
        logic [31:0] rd;
        settle();
        apb_write(DEADZONE_ADDR, word);
        model_deadzone = word[6:0];
        apb_read(DEADZONE_ADDR, rd);
        check_field("deadzone readback", 16'(model_deadzone), 16'(rd[6:0]));
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------
    // Bytes with no frame open produce nothing
    task automatic test_ignored_bytes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h7F);
    endtask

    // Start byte inside a frame restarts it; a bad sum keeps the reset report
    task automatic test_restart_and_bad_sum();
        frame_t f;
        send_byte(gfr_pkg::START_BYTE);
        send_byte(8'h12);
        send_byte(8'h34);
        f = build_frame(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        for (int i = 1; i <= 10; i++)
            f[i] = 8'hFF;
        f[11] = f[11] ^ 8'h01;
        send_frame(f, 12);
    endtask

    // Center, dead zone edge, just past the edge and the negative extreme
    task automatic test_stick_shaping();
        frame_t f;
        f = build_frame(16'hA5C3, 8'h00, 8'hFF, 8'd128, 8'd128 + 8'(model_deadzone),
                        8'd127 - 8'(model_deadzone), 8'd0, 1'b0);
        send_frame(f, 12);
    endtask

    // Spare address is ignored; bits above the field are dropped
    task automatic test_deadzone_register();
        frame_t f;
        settle();
        apb_write(SPARE_ADDR, $urandom);
        set_deadzone({24'hFFFFFF, 8'hFF});
        f = build_frame(16'h5A3C, 8'hFF, 8'h00, 8'd0, 8'd255, 8'd1, 8'd128, 1'b1);
        send_frame(f, 12);
        set_deadzone({25'($urandom_range(0, 33554431)), 7'd0});
        f = build_frame(16'h0001, 8'h80, 8'h01, 8'd127, 8'd129, 8'd0, 8'd255, 1'b1);
        send_frame(f, 12);
    endtask

    // Mostly good frames, some corrupted, truncated and stray bytes
    task automatic send_random_frame();
        frame_t f;
        int kind;
        kind = $urandom_range(0, 9);
        f = build_frame(16'($urandom), 8'($urandom), 8'($urandom), pick_axis(),
                        pick_axis(), pick_axis(), pick_axis(), 1'b1);
        if (kind < 7)
            send_frame(f, 12);
        else if (kind == 7)
        begin
            f[11] = f[11] ^ 8'($urandom_range(1, 255));
            send_frame(f, 12);
        end
        else if (kind == 8)
            send_frame(f, $urandom_range(1, 11));
        else
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    endtask

    task automatic test_random_traffic();
        logic [6:0] setting [4];
        int target;
        setting[0] = 7'd0;
        setting[1] = 7'd127;
        setting[2] = 7'($urandom_range(1, 126));
        setting[3] = gfr_pkg::DEADZONE_RESET;
        for (int phase = 0; phase < 4; phase++)
        begin
            set_deadzone({25'($urandom), setting[phase]});
            target = bytes_sent + 90;
            while (bytes_sent < target)
            begin
                if ($urandom_range(0, 15) == 0)
                    quiet = ~quiet;
                send_random_frame();
            end
        end
        quiet = 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial
    begin
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        rx_byte  = '0;
        quiet    = 1'b0;
        errors       = 0;
        bytes_sent   = 0;
        model_deadzone = gfr_pkg::DEADZONE_RESET;
        model_position = 4'd0;
        model_sum      = 8'd0;
        model_payload  = '0;
        model_report   = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        test_ignored_bytes();
        test_restart_and_bad_sum();
        test_stick_shaping();
        test_deadzone_register();
        test_random_traffic();
        settle();

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Report consumer with random stalls
    initial
    begin
        int stall;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall = pick_gap();
            if (stall == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
        end
    end

    // Compare each delivered word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            observed.checksum_ok          = checksum_ok;
            observed.report.buttons       = buttons;
            observed.report.left_trigger  = left_trigger;
            observed.report.right_trigger = right_trigger;
            observed.report.left_x        = left_x;
            observed.report.left_y        = left_y;
            observed.report.right_x       = right_x;
            observed.report.right_y       = right_y;
            if (pending_reports.size() == 0)
                log_error("report word with nothing expected");
            else
            begin
                wanted = pending_reports.pop_front();
                check_field("checksum_ok", 16'(wanted.checksum_ok),
                            16'(observed.checksum_ok));
                check_field("buttons", wanted.report.buttons, observed.report.buttons);
                check_field("left_trigger", 16'(wanted.report.left_trigger),
                            16'(observed.report.left_trigger));
                check_field("right_trigger", 16'(wanted.report.right_trigger),
                            16'(observed.report.right_trigger));
                check_field("left_x", 16'(wanted.report.left_x),
                            16'(observed.report.left_x));
                check_field("left_y", 16'(wanted.report.left_y),
                            16'(observed.report.left_y));
                check_field("right_x", 16'(wanted.report.right_x),
                            16'(observed.report.right_x));
                check_field("right_y", 16'(wanted.report.right_y),
                            16'(observed.report.right_y));
            end
        end
    end

    // Watchdog: too long with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog expired, %0d words outstanding",
                     $time, pending_reports.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

[files.f]
+incdir+sv
sv/gfr_pkg.sv
sv/gfr_unpack.sv
sv/gfr_out_queue.sv
sv/gamepad_frame_receiver_core.sv
sim/testbench.sv
